### rtl/dem_pkg.sv
`timescale 1ns / 1ps
package dem_pkg;

  localparam int MAX_DIM    = 4;
  localparam int MAX_DEGREE = 3;
  localparam int MAX_DELAY  = 16;
  localparam int LINE_DEPTH = 64;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);
  localparam int RESULT_CAP = 35;
  localparam int FILL_MAX   = 127;

  localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

  typedef enum logic [1:0] {
    REG_DIMENSION  = 2'd0,
    REG_MAX_DEGREE = 2'd1,
    REG_DELAY      = 2'd2,
    REG_NONE       = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CALC,
    S_OUT
  } dem_state_t;

  typedef logic [MAX_DIM-1:0][1:0] exp_vec_t;

  typedef struct packed {
    exp_vec_t exps;
    logic     more;
  } adv_t;

  // odometer step: last used exponent fastest, total degree bounded by deg
  function automatic adv_t odo_advance(exp_vec_t e, logic [2:0] dim, logic [1:0] deg);
    adv_t       r;
    logic [2:0] t;
    logic [4:0] s;
    logic       done;
    r.exps = e;
    r.more = 1'b0;
    done   = 1'b0;
    for (int p = MAX_DIM - 1; p >= 0; p--) begin
      if (!done && p < int'(dim)) begin
        t = {1'b0, r.exps[p]} + 3'd1;
        s = '0;
        for (int i = 0; i < MAX_DIM; i++) begin
          if (i == p) s = s + {2'b00, t};
          else        s = s + {3'b000, r.exps[i]};
        end
        if (s <= {3'b000, deg}) begin
          r.exps[p] = t[1:0];
          r.more    = 1'b1;
          done      = 1'b1;
        end else begin
          r.exps[p] = 2'd0;
        end
      end
    end
    return r;
  endfunction

endpackage

### rtl/dem_sample_if.sv
`timescale 1ns / 1ps
interface dem_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

### rtl/dem_result_if.sv
`timescale 1ns / 1ps
interface dem_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic [5:0]         monomial_index;
  logic [1:0]         exponent_0;
  logic [1:0]         exponent_1;
  logic [1:0]         exponent_2;
  logic [1:0]         exponent_3;
  logic               last_monomial;

  modport source (output valid, output value, output monomial_index, output exponent_0,
                  output exponent_1, output exponent_2, output exponent_3,
                  output last_monomial, input ready);
  modport sink (input valid, input value, input monomial_index, input exponent_0,
                input exponent_1, input exponent_2, input exponent_3,
                input last_monomial, output ready);
endinterface

### rtl/dem_cfg_if.sv
`timescale 1ns / 1ps
interface dem_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [4:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/delay_embedding_monomial_features.sv
`timescale 1ns / 1ps
// channel   dir   word
// samples   in    sample (signed Q1.15)
// results   out   value (Q2.30), monomial_index, exponent_0..3, last_monomial
// cfg       in    index, data (dimension, max_degree, delay)
//
// samples are accepted only in idle; a full window then starts one line read per
// window element, then per monomial one multiply per unit of degree, a step to see the
// multiplies are done and an output step.
// the sample line ram (one write, one read port) sets the read phase, the single
// multiplier sets the calc phase. no sample is taken until the last word is loaded.
// rst is synchronous; the line needs no clearing since a window is only read once filled.
// a stalled result holds in the output register and freezes the sequencer.
module delay_embedding_monomial_features
  import dem_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  dem_sample_if.sink   samples,
  dem_result_if.source results,
  dem_cfg_if.sink      cfg
);

  dem_state_t state, state_next;

  logic [2:0] dimension;
  logic [1:0] max_degree;
  logic [4:0] delay;

  logic [2:0] dim_c;
  logic [4:0] dl_c;
  logic [6:0] span;

  logic [LINE_AW-1:0] wp;
  logic [6:0]         fill;
  logic [6:0]         fill_next;

  logic signed [15:0] v [MAX_DIM];
  logic [2:0]         rd_cnt;
  logic               cap_valid;
  logic [1:0]         cap_idx;
  logic [LINE_AW-1:0] raddr;
  logic [15:0]        rdata;
  logic               rd_en;

  exp_vec_t           e;
  exp_vec_t           rem;
  logic signed [31:0] acc;
  logic signed [31:0] mul_y;
  logic [1:0]         sel_d;
  logic               calc_done;
  logic [5:0]         cnt;
  adv_t               adv;
  logic               is_last;

  logic in_acc;
  logic out_load;
  logic ov;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension  <= 3'd1;
      max_degree <= 2'd1;
      delay      <= 5'd1;
    end else if (cfg.valid) begin
      unique case (cfg_index_t'(cfg.index))
        REG_DIMENSION:  dimension  <= cfg.data[2:0];
        REG_MAX_DEGREE: max_degree <= cfg.data[1:0];
        REG_DELAY:      delay      <= cfg.data;
        REG_NONE:       ;
        default:        ;
      endcase
    end
  end

  always_comb begin
    if (dimension == 3'd0)               dim_c = 3'd1;
    else if (dimension > 3'(MAX_DIM))    dim_c = 3'(MAX_DIM);
    else                                 dim_c = dimension;
    if (delay == 5'd0)                   dl_c = 5'd1;
    else if (delay > 5'(MAX_DELAY))      dl_c = 5'(MAX_DELAY);
    else                                 dl_c = delay;
    span = 7'(dim_c - 3'd1) * 7'(dl_c) + 7'd1;
  end

  assign in_acc    = samples.valid && samples.ready;
  assign fill_next = (fill == 7'(FILL_MAX)) ? fill : fill + 7'd1;

  // read address of element rd_cnt, offset wraps around the line
  assign raddr = wp - LINE_AW'(rd_cnt[1:0]) * LINE_AW'(dl_c);

  dem_line_ram u_line (
    .clk   (clk),
    .we    (in_acc),
    .waddr (wp + LINE_AW'(1)),
    .wdata (samples.sample),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    sel_d     = 2'd0;
    calc_done = 1'b1;
    for (int d = MAX_DIM - 1; d >= 0; d--) begin
      if (rem[d] != 2'd0) begin
        sel_d     = 2'(d);
        calc_done = 1'b0;
      end
    end
  end

  dem_mulsat u_mul (
    .acc (acc),
    .x   (v[sel_d]),
    .y   (mul_y)
  );

  assign adv     = odo_advance(e, dim_c, max_degree);
  assign is_last = !adv.more || (cnt == 6'(RESULT_CAP - 1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_acc && fill_next >= span) state_next = S_READ;
      S_READ: if (rd_cnt == dim_c) state_next = S_CALC;
      S_CALC: if (calc_done) state_next = S_OUT;
      S_OUT:  if (out_load) state_next = is_last ? S_IDLE : S_CALC;
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    samples.ready = 1'b0;
    rd_en         = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      S_IDLE:  samples.ready = 1'b1;
      S_READ:  rd_en = (rd_cnt < dim_c);
      S_CALC:  ;
      S_OUT:   out_load = !ov || results.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wp        <= '0;
      fill      <= '0;
      cap_valid <= 1'b0;
      ov        <= 1'b0;
    end else begin
      state     <= state_next;
      cap_valid <= rd_en;
      if (in_acc) begin
        wp   <= wp + LINE_AW'(1);
        fill <= fill_next;
      end
      if (out_load)           ov <= 1'b1;
      else if (results.ready) ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cap_idx <= rd_cnt[1:0];
    if (cap_valid) v[cap_idx] <= rdata;
    unique case (state)
      S_IDLE: begin
        rd_cnt <= '0;
        e      <= '0;
        rem    <= '0;
        cnt    <= '0;
        acc    <= ONE_Q30;
      end
      S_READ:  rd_cnt <= rd_cnt + 3'd1;
      S_CALC: begin
        if (!calc_done) begin
          acc        <= mul_y;
          rem[sel_d] <= rem[sel_d] - 2'd1;
        end
      end
      S_OUT: begin
        if (out_load) begin
          e   <= is_last ? '0 : adv.exps;
          rem <= is_last ? '0 : adv.exps;
          cnt <= cnt + 6'd1;
          acc <= ONE_Q30;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      results.value          <= acc;
      results.monomial_index <= cnt;
      results.exponent_0     <= e[0];
      results.exponent_1     <= e[1];
      results.exponent_2     <= e[2];
      results.exponent_3     <= e[3];
      results.last_monomial  <= is_last;
    end
  end

  assign results.valid = ov;

endmodule

### rtl/dem_line_ram.sv
`timescale 1ns / 1ps
module dem_line_ram
  import dem_pkg::*;
(
  input  logic               clk,
  input  logic               we,
  input  logic [LINE_AW-1:0] waddr,
  input  logic [15:0]        wdata,
  input  logic               re,
  input  logic [LINE_AW-1:0] raddr,
  output logic [15:0]        rdata
);

  logic [15:0] mem [LINE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

### rtl/dem_mulsat.sv
`timescale 1ns / 1ps
module dem_mulsat
  import dem_pkg::*;
(
  input  logic signed [31:0] acc,
  input  logic signed [15:0] x,
  output logic signed [31:0] y
);

  logic signed [47:0] prod;
  logic signed [48:0] rnd;
  logic signed [33:0] q;

  always_comb begin
    prod = acc * x;
    rnd  = 49'(prod) + 49'sd16384;
    // arithmetic shift floors, giving round half up
    q    = 34'(rnd >>> 15);
    if (q > 34'sh0_7FFF_FFFF)       y = 32'sh7FFF_FFFF;
    else if (q < -34'sh0_8000_0000) y = 32'sh8000_0000;
    else                            y = q[31:0];
  end

endmodule
